[hw/rtl/mm4x4_pkg.sv]
// ----------------------------------------------------------------------------
// mm4x4_pkg
// Shared types and constants of the fixed-point 4x4 matrix multiply unit.
// ----------------------------------------------------------------------------
package mm4x4_pkg;

  localparam int unsigned Dim  = 4;
  localparam int unsigned IdxW = (Dim > 1) ? $clog2(Dim) : 1;
  localparam int unsigned AccW = 48 + IdxW;

  localparam logic [IdxW-1:0] IdxLast = IdxW'(Dim - 1);

  localparam logic OpWrite  = 1'b0;
  localparam logic OpMult   = 1'b1;
  localparam logic SelLeft  = 1'b0;
  localparam logic SelRight = 1'b1;

  typedef struct packed {
    logic            valid;
    logic            first;
    logic            last_k;
    logic            last_elem;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
  } mac_tag_t;

endpackage

[hw/rtl/mm4x4_mac.sv]
// ----------------------------------------------------------------------------
// mm4x4_mac
// Shared multiply-accumulate pipeline: Q16.16 product, floor shift by 16,
// running dot-product sum and saturation to 32 bits.
// ----------------------------------------------------------------------------
module mm4x4_mac
  import mm4x4_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mac_tag_t           tag_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               res_valid_o,
  output logic [1:0]         res_row_o,
  output logic [1:0]         res_col_o,
  output logic signed [31:0] res_value_o,
  output logic               res_last_o
);

  localparam logic signed [AccW-1:0] SatMax = AccW'(64'sh0000_0000_7fff_ffff);
  localparam logic signed [AccW-1:0] SatMin = AccW'(64'shffff_ffff_8000_0000);

  mac_tag_t                tag_b_q, tag_c_q;
  logic signed [63:0]      prod_q;
  logic signed [63:0]      prod_sh;
  logic signed [AccW-1:0]  term;
  logic signed [AccW-1:0]  acc_d, acc_q;
  logic                    valid_q;
  logic [1:0]              row_q, col_q;
  logic signed [31:0]      value_q;
  logic                    last_q;

  assign prod_sh = prod_q >>> 16;
  assign term    = AccW'(prod_sh);
  assign acc_d   = (tag_b_q.first ? '0 : acc_q) + term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_b_q <= '0;
      tag_c_q <= '0;
      valid_q <= 1'b0;
    end else begin
      tag_b_q <= tag_i;
      tag_c_q <= tag_b_q;
      valid_q <= tag_c_q.valid & tag_c_q.last_k;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (tag_b_q.valid) begin
      acc_q <= acc_d;
    end
    row_q  <= 2'(tag_c_q.row);
    col_q  <= 2'(tag_c_q.col);
    last_q <= tag_c_q.last_elem;
    if (acc_q > SatMax) begin
      value_q <= 32'sh7fff_ffff;
    end else if (acc_q < SatMin) begin
      value_q <= 32'sh8000_0000;
    end else begin
      value_q <= acc_q[31:0];
    end
  end

  assign res_valid_o = valid_q;
  assign res_row_o   = row_q;
  assign res_col_o   = col_q;
  assign res_value_o = value_q;
  assign res_last_o  = valid_q & last_q;

endmodule

[hw/rtl/matrix4x4_multiply_unit.sv]
// ----------------------------------------------------------------------------
// matrix4x4_multiply_unit
// Left and right 4x4 Q16.16 matrices (identity after reset), element writes
// and a product read out as sixteen words in row-major order.
//
//   port group                          dir  role
//   start, op_i, matrix_sel_i, in_row_i,
//     in_col_i, elem_value_i            in   command word, taken on start & !busy
//   result_valid_o, out_row_o,
//     out_col_o, prod_value_o, last_o   out  product word, one-cycle strobe
//
// A write command leaves busy low.
// A multiply command holds busy through its final product word:
// the single 32x32 multiplier takes one term per cycle, one word per dot product.
// Reset loads identity into both matrices and returns to idle.
// The receiver cannot stall: each word is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module matrix4x4_multiply_unit
  import mm4x4_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic               matrix_sel_i,
  input  logic [1:0]         in_row_i,
  input  logic [1:0]         in_col_i,
  input  logic signed [31:0] elem_value_i,
  output logic               result_valid_o,
  output logic [1:0]         out_row_o,
  output logic [1:0]         out_col_o,
  output logic signed [31:0] prod_value_o,
  output logic               last_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;

  localparam logic signed [31:0] OneQ16 = 32'sh0001_0000;

  logic [1:0]         state_d, state_q;
  logic [IdxW-1:0]    i_d, i_q, j_d, j_q, k_d, k_q;
  logic signed [31:0] left_q  [Dim][Dim];
  logic signed [31:0] right_q [Dim][Dim];
  logic signed [31:0] a_q, b_q;
  mac_tag_t           tag_a_d, tag_a_q;
  logic               accept;
  logic               wr_en;
  logic               issue_last;
  logic               res_valid, res_last;
  logic [1:0]         res_row, res_col;
  logic signed [31:0] res_value;

  assign busy       = (state_q != StIdle);
  assign accept     = start & ~busy;
  assign wr_en      = accept & (op_i == OpWrite) &
                      (32'(in_row_i) < Dim) & (32'(in_col_i) < Dim);
  assign issue_last = (i_q == IdxLast) & (j_q == IdxLast) & (k_q == IdxLast);

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    case (state_q)
      StIdle: begin
        if (accept && op_i == OpMult) begin
          state_d = StIssue;
        end
      end
      StIssue: begin
        if (k_q == IdxLast) begin
          k_d = '0;
          if (j_q == IdxLast) begin
            j_d = '0;
            i_d = (i_q == IdxLast) ? '0 : i_q + 1'b1;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
        if (issue_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (res_valid && res_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    tag_a_d.valid     = (state_q == StIssue);
    tag_a_d.first     = (k_q == '0);
    tag_a_d.last_k    = (k_q == IdxLast);
    tag_a_d.last_elem = (i_q == IdxLast) & (j_q == IdxLast);
    tag_a_d.row       = i_q;
    tag_a_d.col       = j_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      tag_a_q <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      tag_a_q <= tag_a_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < Dim; r++) begin
        for (int c = 0; c < Dim; c++) begin
          left_q[r][c]  <= (r == c) ? OneQ16 : '0;
          right_q[r][c] <= (r == c) ? OneQ16 : '0;
        end
      end
    end else if (wr_en) begin
      if (matrix_sel_i == SelRight) begin
        right_q[IdxW'(in_row_i)][IdxW'(in_col_i)] <= elem_value_i;
      end else begin
        left_q[IdxW'(in_row_i)][IdxW'(in_col_i)] <= elem_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= left_q[i_q][k_q];
    b_q <= right_q[k_q][j_q];
  end

  mm4x4_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag_a_q),
    .a_i         (a_q),
    .b_i         (b_q),
    .res_valid_o (res_valid),
    .res_row_o   (res_row),
    .res_col_o   (res_col),
    .res_value_o (res_value),
    .res_last_o  (res_last)
  );

  assign result_valid_o = res_valid;
  assign out_row_o      = res_row;
  assign out_col_o      = res_col;
  assign prod_value_o   = res_value;
  assign last_o         = res_last;

  a_word_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("product word outside a multiply");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !busy)
    else $error("busy held after final word");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !$past(busy)) |-> $past(start && op_i == OpMult))
    else $error("busy rose without a multiply command");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> (out_row_o == 2'(IdxLast) && out_col_o == 2'(IdxLast)))
    else $error("final word not at last row and column");

  a_no_word_idle_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIssue && i_q == '0 && j_q == '0) |-> !result_valid_o)
    else $error("word emitted before first dot product");

endmodule

[verif/matrix4x4_multiply_unit_tb.sv]
// ----------------------------------------------------------------------------
// matrix4x4_multiply_unit_tb
// Drives element writes and multiply commands into the 4x4 Q16.16 matrix
// multiply unit and checks every product word against a local model of the
// two matrices (floored Q16.16 terms, exact sum, 32-bit saturation). A short
// table of commands covers reset identity and the saturation extremes, then
// random commands run under several sender pacing modes.
// ----------------------------------------------------------------------------
module matrix4x4_multiply_unit_tb;
  import mm4x4_pkg::*;

  localparam int unsigned ElemCnt    = Dim * Dim;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned TailCycles = Dim * Dim * Dim + 16;
  localparam int unsigned RandItems  = 420;
  localparam int unsigned TblRows    = 22;

  typedef struct packed {
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
    logic               last;
  } product_word_t;

  typedef struct packed {
    logic               op;
    logic               sel;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
    logic               golden;
    logic signed [31:0] diag;
  } cmd_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               op_i;
  logic               matrix_sel_i;
  logic [1:0]         in_row_i;
  logic [1:0]         in_col_i;
  logic signed [31:0] elem_value_i;
  logic               result_valid_o;
  logic [1:0]         out_row_o;
  logic [1:0]         out_col_o;
  logic signed [31:0] prod_value_o;
  logic               last_o;

  logic signed [31:0] lhs_mat [ElemCnt];
  logic signed [31:0] rhs_mat [ElemCnt];
  product_word_t      pending_words [$];
  cmd_row_t           directed_tbl [TblRows];

  int unsigned err_count;
  int unsigned write_count;
  int unsigned mult_count;
  int unsigned word_count;
  int unsigned quiet_cycles;

  matrix4x4_multiply_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .matrix_sel_i   (matrix_sel_i),
    .in_row_i       (in_row_i),
    .in_col_i       (in_col_i),
    .elem_value_i   (elem_value_i),
    .result_valid_o (result_valid_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .prod_value_o   (prod_value_o),
    .last_o         (last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic reset_matrices();
    for (int n = 0; n < ElemCnt; n++) begin
      lhs_mat[n] = (n / Dim == n % Dim) ? 32'sh0001_0000 : 32'sh0;
      rhs_mat[n] = (n / Dim == n % Dim) ? 32'sh0001_0000 : 32'sh0;
    end
  endtask

  function automatic logic signed [31:0] dot_q16(int unsigned i, int unsigned j);
    longint acc;
    longint term;
    acc = 0;
    for (int unsigned k = 0; k < Dim; k++) begin
      term = longint'(lhs_mat[i * Dim + k]) * longint'(rhs_mat[k * Dim + j]);
      acc += term >>> 16;
    end
    if (acc > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (acc < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
    return acc[31:0];
  endfunction

  task automatic queue_product(input logic use_diag, input logic signed [31:0] diag);
    product_word_t w;
    for (int unsigned i = 0; i < Dim; i++) begin
      for (int unsigned j = 0; j < Dim; j++) begin
        w.row   = i[1:0];
        w.col   = j[1:0];
        w.last  = (i == Dim - 1) && (j == Dim - 1);
        w.value = use_diag ? ((i == j) ? diag : 32'sh0) : dot_q16(i, j);
        pending_words.push_back(w);
      end
    end
  endtask

  task automatic apply_command(input cmd_row_t c);
    if (c.op == OpWrite) begin
      write_count++;
      if (c.row < Dim && c.col < Dim) begin
        if (c.sel == SelRight) rhs_mat[c.row * Dim + c.col] = c.value;
        else lhs_mat[c.row * Dim + c.col] = c.value;
      end
    end else begin
      mult_count++;
      queue_product(c.golden, c.diag);
    end
  endtask

  function automatic logic signed [31:0] rand_elem();
    int unsigned pick;
    pick = $urandom_range(9);
    case (pick)
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0;
      3: return ($urandom_range(1) != 0) ? 32'sh0001_0000 : -32'sh0001_0000;
      4, 5, 6: return $signed($urandom_range(0, (1 << 20) - 1)) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  task automatic drive_idle();
    @(negedge clk_i);
    start        <= 1'b0;
    op_i         <= 1'($urandom_range(1));
    matrix_sel_i <= 1'($urandom_range(1));
    in_row_i     <= 2'($urandom_range(3));
    in_col_i     <= 2'($urandom_range(3));
    elem_value_i <= $urandom;
  endtask

  task automatic send_command(input cmd_row_t c, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) drive_idle();
    @(negedge clk_i);
    start        <= 1'b1;
    op_i         <= c.op;
    matrix_sel_i <= c.sel;
    in_row_i     <= c.row;
    in_col_i     <= c.col;
    elem_value_i <= c.value;
    do @(posedge clk_i); while (busy);
    apply_command(c);
  endtask

  task automatic wait_drained();
    drive_idle();
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // check product words in arrival order
  always @(posedge clk_i) begin
    product_word_t w;
    if (rst_ni && result_valid_o) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", prod_value_o, 32'h0);
      end else begin
        w = pending_words.pop_front();
        word_count++;
        if (out_row_o != w.row) report_mismatch("out_row", 32'(out_row_o), 32'(w.row));
        if (out_col_o != w.col) report_mismatch("out_col", 32'(out_col_o), 32'(w.col));
        if (prod_value_o !== w.value) report_mismatch("prod_value", prod_value_o, w.value);
        if (last_o != w.last) report_mismatch("last", 32'(last_o), 32'(w.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no handshake for %0d cycles", StallLimit);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cmd_row_t c;
    int unsigned idle_pct;

    err_count    = 0;
    write_count  = 0;
    mult_count   = 0;
    word_count   = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    op_i         = OpWrite;
    matrix_sel_i = SelLeft;
    in_row_i     = '0;
    in_col_i     = '0;
    elem_value_i = '0;
    reset_matrices();

    directed_tbl = '{
      '{OpMult,  SelRight, 2'd3, 2'd2, 32'sh5A5A_5A5A, 1'b1, 32'sh0001_0000},
      '{OpWrite, SelLeft,  2'd0, 2'd0, 32'sh8000_0000, 1'b0, 32'sh0},
      '{OpWrite, SelLeft,  2'd1, 2'd1, 32'sh8000_0000, 1'b0, 32'sh0},
      '{OpWrite, SelLeft,  2'd2, 2'd2, 32'sh8000_0000, 1'b0, 32'sh0},
      '{OpWrite, SelLeft,  2'd3, 2'd3, 32'sh8000_0000, 1'b0, 32'sh0},
      '{OpMult,  SelLeft,  2'd0, 2'd0, 32'sh0,         1'b1, 32'sh8000_0000},
      '{OpWrite, SelRight, 2'd0, 2'd0, 32'sh8000_0000, 1'b0, 32'sh0},
      '{OpWrite, SelRight, 2'd1, 2'd1, 32'sh8000_0000, 1'b0, 32'sh0},
      '{OpWrite, SelRight, 2'd2, 2'd2, 32'sh8000_0000, 1'b0, 32'sh0},
      '{OpWrite, SelRight, 2'd3, 2'd3, 32'sh8000_0000, 1'b0, 32'sh0},
      '{OpMult,  SelRight, 2'd1, 2'd1, 32'shFFFF_FFFF, 1'b1, 32'sh7FFF_FFFF},
      '{OpWrite, SelRight, 2'd0, 2'd0, 32'sh7FFF_FFFF, 1'b0, 32'sh0},
      '{OpWrite, SelRight, 2'd1, 2'd1, 32'sh7FFF_FFFF, 1'b0, 32'sh0},
      '{OpWrite, SelRight, 2'd2, 2'd2, 32'sh7FFF_FFFF, 1'b0, 32'sh0},
      '{OpWrite, SelRight, 2'd3, 2'd3, 32'sh7FFF_FFFF, 1'b0, 32'sh0},
      '{OpMult,  SelLeft,  2'd3, 2'd3, 32'sh7FFF_FFFF, 1'b1, 32'sh8000_0000},
      '{OpWrite, SelLeft,  2'd0, 2'd0, 32'shFFFF_FFFF, 1'b0, 32'sh0},
      '{OpWrite, SelLeft,  2'd3, 2'd0, 32'sh0000_0001, 1'b0, 32'sh0},
      '{OpWrite, SelRight, 2'd0, 2'd3, 32'shFFFF_FFFF, 1'b0, 32'sh0},
      '{OpWrite, SelLeft,  2'd1, 2'd2, 32'sh0001_8000, 1'b0, 32'sh0},
      '{OpWrite, SelRight, 2'd2, 2'd1, 32'shFFFF_8000, 1'b0, 32'sh0},
      '{OpMult,  SelLeft,  2'd2, 2'd1, 32'sh1234_5678, 1'b0, 32'sh0}
    };

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_tbl[r]) send_command(directed_tbl[r], 0);
    wait_drained();

    // pacing modes: back to back, heavy sender gaps, light sender gaps
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 72 : 23;
      for (int unsigned n = 0; n < RandItems / 3; n++) begin
        c.op     = ($urandom_range(99) < 12) ? OpMult : OpWrite;
        c.sel    = 1'($urandom_range(1));
        c.row    = 2'($urandom_range(3));
        c.col    = 2'($urandom_range(3));
        c.value  = rand_elem();
        c.golden = 1'b0;
        c.diag   = '0;
        send_command(c, idle_pct);
      end
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d element writes and %0d products (%0d words compared)",
             write_count, mult_count, word_count);
    $display("pacing: back to back, sparse and light sender gaps, drained between modes");
    if (err_count == 0 && pending_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d words still expected", err_count, pending_words.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
